[rtl/scaled_convert_to_bf16_core_assert.svh]
// Assertion macros for the scaled bf16 converter.
// Used by the top level only; no other dependencies.
`ifndef SCALED_CONVERT_TO_BF16_CORE_ASSERT_SVH
`define SCALED_CONVERT_TO_BF16_CORE_ASSERT_SVH

// Check that a condition implies a consequence on the same edge.
`define SCB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence on the next edge.
`define SCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/scb_pkg.sv]
// Shared types and constants for the scaled bf16 converter.
// No dependencies.
package scb_pkg;

  typedef enum logic [1:0] {
    MODE_BF16 = 2'd0,
    MODE_FP16 = 2'd1,
    MODE_FP32 = 2'd2,
    MODE_BAD  = 2'd3
  } mode_t;

  localparam logic [31:0] ONE_F32     = 32'h3f80_0000;
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'hffc0_0000;
  localparam logic [15:0] RND_BIAS    = 16'h7fff;

  // Stage-1 to stage-2 bundle.
  typedef struct packed {
    logic        special;
    logic [31:0] special_val;
    logic        sign;
    logic [9:0]  exp_sum;
    logic [47:0] prod;
  } mul_s1_t;

  typedef struct packed {
    logic        pass;
    logic        err;
    logic        last;
    logic [15:0] pass_val;
  } ctl_t;

  function automatic logic [15:0] narrow16(input logic [31:0] u);
    logic [31:0] s;
    begin
      s = u + {16'd0, RND_BIAS} + {31'd0, u[16]};
      narrow16 = s[31:16];
    end
  endfunction

endpackage

[rtl/scaled_convert_to_bf16_core.sv]
// Top level of the scaled bf16 converter: multiplies each element by the scale
// register in fp32 and rounds to bf16. Uses scb_pkg, scb_widen, scb_round.
// Two register stages (stage 1 and the result register): one item per cycle while
// the output does not stall. The 24x24 significand multiplier is registered
// between widening and rounding; the result register is backed by a one-entry
// skid buffer so in_ready comes from a register: when the output stalls, one more
// item is taken and then the input stalls until the skid buffer drains.
`include "scaled_convert_to_bf16_core_assert.svh"
module scaled_convert_to_bf16_core import scb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_scale_bits,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_element_bits,
  input  logic        in_last_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_bf16_value,
  output logic        out_format_error,
  output logic        out_last_out
);

  logic [31:0] scale_r;
  logic [31:0] wide;
  mul_s1_t     s1_nxt, s1_r;
  ctl_t        ctl_nxt, ctl_r;
  logic        v1_r;
  logic [31:0] prod32;
  logic [17:0] res_nxt;
  logic [17:0] o_r, skid_r;
  logic        ov_r, sv_r;
  logic        adv;

  assign cfg_ready = 1'b1;
  assign in_ready  = !sv_r;
  assign adv       = v1_r && !sv_r;

  scb_widen u_widen (.mode(in_mode), .element_bits(in_element_bits), .wide(wide));

  always_comb begin
    logic a_nan, b_nan, a_inf, b_inf, a_z, b_z;
    a_nan = (wide[30:23] == 8'hff) && (wide[22:0] != 23'd0);
    b_nan = (scale_r[30:23] == 8'hff) && (scale_r[22:0] != 23'd0);
    a_inf = wide[30:0] == 31'h7f80_0000;
    b_inf = scale_r[30:0] == 31'h7f80_0000;
    a_z   = wide[30:0] == 31'd0;
    b_z   = scale_r[30:0] == 31'd0;
    s1_nxt.sign = wide[31] ^ scale_r[31];
    s1_nxt.special = 1'b1;
    if (a_nan) s1_nxt.special_val = wide | QUIET_BIT;
    else if (b_nan) s1_nxt.special_val = scale_r | QUIET_BIT;
    else if ((a_inf && b_z) || (a_z && b_inf)) s1_nxt.special_val = DEFAULT_NAN;
    else if (a_inf || b_inf) s1_nxt.special_val = {s1_nxt.sign, 31'h7f80_0000};
    else if (a_z || b_z) s1_nxt.special_val = {s1_nxt.sign, 31'd0};
    else begin
      s1_nxt.special = 1'b0;
      s1_nxt.special_val = 32'd0;
    end
    s1_nxt.exp_sum = {2'b00, (wide[30:23] == 8'd0) ? 8'd1 : wide[30:23]}
                   + {2'b00, (scale_r[30:23] == 8'd0) ? 8'd1 : scale_r[30:23]};
    s1_nxt.prod = {(wide[30:23] != 8'd0), wide[22:0]}
                * {(scale_r[30:23] != 8'd0), scale_r[22:0]};
    ctl_nxt.pass = (mode_t'(in_mode) == MODE_BF16) && (scale_r == ONE_F32);
    ctl_nxt.err = mode_t'(in_mode) == MODE_BAD;
    ctl_nxt.last = in_last_in;
    ctl_nxt.pass_val = in_element_bits[15:0];
  end

  scb_round u_round (.s1(s1_r), .result(prod32));

  always_comb begin
    if (ctl_r.err) res_nxt = {16'd0, 1'b1, ctl_r.last};
    else if (ctl_r.pass) res_nxt = {ctl_r.pass_val, 1'b0, ctl_r.last};
    else res_nxt = {narrow16(prod32), 1'b0, ctl_r.last};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= ONE_F32;
      v1_r    <= 1'b0;
      ov_r    <= 1'b0;
      sv_r    <= 1'b0;
    end else begin
      if (cfg_valid) scale_r <= cfg_scale_bits;
      if (in_ready) begin
        v1_r  <= in_valid;
        s1_r  <= s1_nxt;
        ctl_r <= ctl_nxt;
      end
      // Output register with skid: hold stalled result, park the next one.
      if (!ov_r || out_ready) begin
        if (sv_r) begin
          o_r  <= skid_r;
          ov_r <= 1'b1;
          sv_r <= 1'b0;
        end else begin
          o_r  <= res_nxt;
          ov_r <= adv;
        end
      end else if (adv) begin
        skid_r <= res_nxt;
        sv_r   <= 1'b1;
      end
    end
  end

  assign out_valid        = ov_r;
  assign out_bf16_value   = o_r[17:2];
  assign out_format_error = o_r[1];
  assign out_last_out     = o_r[0];

  `SCB_ASSERT_IMPL(a_skid_needs_out, sv_r, ov_r)
  `SCB_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(o_r))
  `SCB_ASSERT_IMPL(a_err_zero, out_valid && out_format_error, out_bf16_value == 16'd0)

endmodule

[rtl/scb_widen.sv]
// Widen a bf16, fp16 or fp32 element to fp32 bits exactly.
// Depends on scb_pkg.
module scb_widen import scb_pkg::*; (
  input  logic [1:0]  mode,
  input  logic [31:0] element_bits,
  output logic [31:0] wide
);

  logic [9:0]  man;
  logic [4:0]  ex;
  logic [3:0]  lz;
  logic [9:0]  norm;
  logic [31:0] half;

  always_comb begin
    man = element_bits[9:0];
    ex  = element_bits[14:10];
    lz  = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) lz = 4'(9 - i);
    end
    norm = 10'(man << (lz + 4'd1));
    if (ex == 5'd0) begin
      if (man == 10'd0) half = {element_bits[15], 31'd0};
      else half = {element_bits[15], 8'(8'd112 - {4'd0, lz}), norm, 13'd0};
    end else if (ex == 5'd31) begin
      half = {element_bits[15], 8'hff, man, 13'd0};
    end else begin
      half = {element_bits[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
    end
    unique case (mode_t'(mode))
      MODE_BF16: wide = {element_bits[15:0], 16'd0};
      MODE_FP16: wide = half;
      MODE_FP32: wide = element_bits;
      default:   wide = 32'd0;
    endcase
  end

endmodule

[rtl/scb_round.sv]
// Normalize and round a 24x24 significand product to fp32, subnormals kept.
// Depends on scb_pkg.
module scb_round import scb_pkg::*; (
  input  mul_s1_t     s1,
  output logic [31:0] result
);

  logic               top;
  logic [47:0]        p;
  logic signed [11:0] e;
  logic [5:0]         sh;
  logic [47:0]        q;
  logic               sticky;
  logic [23:0]        m;
  logic               g;
  logic [24:0]        mr;
  logic signed [11:0] ef;
  logic [5:0]         lz;

  always_comb begin
    // Product exponent (biased) for a product in [1,2) after normalizing.
    p   = s1.prod;
    top = p[47];
    e   = $signed({2'b00, s1.exp_sum}) - 12'sd127 + (top ? 12'sd1 : 12'sd0);
    if (!top) p = p << 1;
    // Subnormal operand products may need more left shift.
    lz = 6'd0;
    for (int i = 0; i < 47; i++) begin
      if (p[i]) lz = 6'(47 - i);
    end
    if (!p[47] && p != 48'd0) begin
      if (e - $signed({6'd0, lz}) >= 12'sd1) begin
        p = p << lz;
        e = e - $signed({6'd0, lz});
      end else if (e > 12'sd1) begin
        p = p << 6'(e - 12'sd1);
        e = 12'sd1;
      end
    end
    sh = 6'd0;
    if (e < 12'sd1) sh = (12'sd1 - e > 12'sd40) ? 6'd40 : 6'(12'sd1 - e);
    q = p >> sh;
    sticky = 1'b0;
    for (int i = 0; i < 48; i++) begin
      if (i < sh && p[i]) sticky = 1'b1;
    end
    m  = q[47:24];
    g  = q[23];
    sticky = sticky | (|q[22:0]);
    mr = {1'b0, m} + {24'd0, g & (sticky | m[0])};
    ef = (e < 12'sd1 || !q[47]) ? 12'sd0 : e;
    if (mr[24]) begin
      mr = mr >> 1;
      ef = ef + 12'sd1;
    end else if (ef == 12'sd0 && mr[23]) begin
      ef = 12'sd1;
    end
    if (s1.special) result = s1.special_val;
    else if (ef >= 12'sd255) result = {s1.sign, 8'hff, 23'd0};
    else result = {s1.sign, ef[7:0], mr[22:0]};
  end

endmodule

[tb/sv/tb_scaled_convert_to_bf16_core.sv]
`timescale 1ns / 100ps
// Testbench for scaled_convert_to_bf16_core: streams elements under several scale
// settings and checks every bf16 word against a bit-exact fp32 multiply model.
// Depends on scb_pkg and the RTL of the converter.
module tb_scaled_convert_to_bf16_core;
  import scb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic [15:0] value;
    logic        err;
    logic        last;
  } bf16_word_t;

  class bf16_scoreboard;
    logic [31:0] scale;
    bf16_word_t  pending[$];
    int          errors;

    function new();
      scale = ONE_F32;
      errors = 0;
    endfunction

    static function logic [31:0] widen_half(logic [15:0] h);
      logic [31:0] sgn;
      logic [4:0]  ex;
      logic [10:0] man;
      logic [7:0]  e;
      sgn = {h[15], 31'd0};
      ex = h[14:10];
      man = {1'b0, h[9:0]};
      if (ex == 5'd0) begin
        if (man == 11'd0) return sgn;
        e = 8'd113;
        while (!man[10]) begin
          man = man << 1;
          e = e - 8'd1;
        end
        return sgn | {1'b0, e, man[9:0], 13'd0};
      end
      if (ex == 5'd31) return sgn | 32'h7f80_0000 | {9'd0, man[9:0], 13'd0};
      return sgn | {1'b0, 3'b000, ex, 23'd0} + {1'b0, 8'd112, 23'd0} | {9'd0, man[9:0], 13'd0};
    endfunction

    static function logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
      logic        sgn;
      logic [23:0] ma, mb;
      int          ea, eb, be, lz, sh;
      logic [47:0] p;
      logic [63:0] x;
      logic [24:0] m;
      logic        guard, sticky;
      longint      res;
      if (a[30:23] == 8'hff && a[22:0] != 0) return a | QUIET_BIT;
      if (b[30:23] == 8'hff && b[22:0] != 0) return b | QUIET_BIT;
      sgn = a[31] ^ b[31];
      if ((a[30:0] == 31'h7f80_0000 && b[30:0] == 0) ||
          (a[30:0] == 0 && b[30:0] == 31'h7f80_0000)) return DEFAULT_NAN;
      if (a[30:23] == 8'hff || b[30:23] == 8'hff) return {sgn, 31'h7f80_0000};
      if (a[30:0] == 0 || b[30:0] == 0) return {sgn, 31'd0};
      ea = (a[30:23] == 0) ? 1 : a[30:23];
      eb = (b[30:23] == 0) ? 1 : b[30:23];
      ma = {a[30:23] != 0, a[22:0]};
      mb = {b[30:23] != 0, b[22:0]};
      p = ma * mb;
      lz = 0;
      while (!p[47]) begin
        p = p << 1;
        lz++;
      end
      be = ea + eb - 126 - lz;
      x = {p, 16'd0};
      if (be <= 0) begin
        sh = 1 - be;
        if (sh > 62) sh = 62;
        sticky = (x & ((64'd1 << sh) - 64'd1)) != 0;
        x = (x >> sh) | {63'd0, sticky};
      end
      m = {1'b0, x[63:40]};
      guard = x[39];
      sticky = x[38:0] != 0;
      if (guard && (sticky || m[0])) m = m + 25'd1;
      if (be <= 0) res = m;
      else res = (longint'(be - 1) << 23) + m;
      if (res >= 64'h7f80_0000) return {sgn, 31'h7f80_0000};
      return {sgn, res[30:0]};
    endfunction

    function void note_element(mode_t mode, logic [31:0] elem, logic last);
      bf16_word_t w;
      w.err = 1'b0;
      w.last = last;
      w.value = 16'd0;
      case (mode)
        MODE_BF16: begin
          if (scale == ONE_F32) w.value = elem[15:0];
          else w.value = narrow(fmul({elem[15:0], 16'd0}, scale));
        end
        MODE_FP16: w.value = narrow(fmul(widen_half(elem[15:0]), scale));
        MODE_FP32: w.value = narrow(fmul(elem, scale));
        default: w.err = 1'b1;
      endcase
      pending = {pending, w};
    endfunction

    static function logic [15:0] narrow(logic [31:0] u);
      logic [31:0] s;
      s = u + 32'h7fff + {31'd0, u[16]};
      return s[31:16];
    endfunction

    task report(string what, int got, int want);
      $display("MISMATCH %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check_word(logic [15:0] value, logic err, logic last);
      bf16_word_t w;
      if (pending.size() == 0) begin
        report("unexpected output", value, 0);
      end else begin
        w = pending.pop_front();
        if (value !== w.value) report("bf16_value", value, w.value);
        if (err !== w.err) report("format_error", err, w.err);
        if (last !== w.last) report("last_out", last, w.last);
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_scale_bits = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = '0;
  logic [31:0] in_element_bits = '0;
  logic        in_last_in = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_bf16_value;
  logic        out_format_error;
  logic        out_last_out;

  bf16_scoreboard sb = new();
  bit idle_on = 1'b1;
  int cycles = 0;

  scaled_convert_to_bf16_core u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_scale_bits(cfg_scale_bits),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_element_bits(in_element_bits), .in_last_in(in_last_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_bf16_value(out_bf16_value),
    .out_format_error(out_format_error), .out_last_out(out_last_out)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= !(idle_on && $urandom_range(99) < 11);
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_word(out_bf16_value, out_format_error, out_last_out);
  end

  function automatic logic [31:0] rand_f32();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(7))
      0: r[30:0] = 31'd0;
      1: r[30:23] = 8'd0;
      2: r[30:23] = 8'hff;
      3: r[30:0] = 31'h7f80_0000;
      4: r[30:23] = 8'd120 + 8'($urandom_range(15));
      5: r[30:23] = 8'($urandom_range(3)) + (r[23] ? 8'd250 : 8'd1);
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_f16();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(5))
      0: r[14:0] = 15'd0;
      1: r[14:10] = 5'd0;
      2: r[14:10] = 5'd31;
      3: r[14:0] = 15'h7c00;
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_element(mode_t mode, logic [31:0] elem, logic last);
    if (idle_on && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_element_bits <= elem;
    in_last_in <= last;
    do @(negedge clk); while (!in_ready);
    sb.note_element(mode, elem, last);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(logic [31:0] s);
    cfg_valid <= 1'b1;
    cfg_scale_bits <= s;
    do @(negedge clk); while (!cfg_ready);
    sb.scale = s;
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random(int n);
    mode_t m;
    logic [31:0] e;
    for (int i = 0; i < n; i++) begin
      m = mode_t'($urandom_range(3));
      case (m)
        MODE_BF16: e = {16'($urandom_range(65535)), 16'd0} | (rand_f32() >> 16);
        MODE_FP16: e = rand_f16();
        default: e = rand_f32();
      endcase
      send_element(m, e, 1'($urandom_range(1)));
      if (i == n / 2 && $urandom_range(3) == 0) drain();
    end
  endtask

  logic [31:0] scales[$] = '{ONE_F32, 32'h4000_0000, 32'h0000_0000, 32'h8000_0000,
                             32'h7f80_0000, 32'hff80_0000, 32'h7fa0_0001, 32'hffc0_0000,
                             32'h7f7f_ffff, 32'h0000_0001, 32'hbf80_0000, 32'hffff_ffff,
                             32'h3f7f_ffff};

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_element(MODE_BF16, 32'hffff_3f81, 1'b0);
    send_element(MODE_BF16, 32'h0000_7fc1, 1'b1);
    send_element(MODE_FP16, 32'h0000_0001, 1'b0);
    send_element(MODE_FP16, 32'hffff_83ff, 1'b0);
    send_element(MODE_FP16, 32'h0000_7c00, 1'b1);
    send_element(MODE_FP16, 32'h1234_fe01, 1'b0);
    send_element(MODE_FP16, 32'h0000_7bff, 1'b0);
    send_element(MODE_FP32, 32'h7f80_0001, 1'b0);
    send_element(MODE_FP32, 32'hff80_0000, 1'b1);
    send_element(MODE_FP32, 32'h7f7f_ffff, 1'b0);
    send_element(MODE_FP32, 32'h0000_0001, 1'b0);
    send_element(MODE_FP32, 32'h3f80_8000, 1'b0);
    send_element(MODE_FP32, 32'h3f81_8000, 1'b1);
    send_element(MODE_FP32, 32'h0000_0000, 1'b0);
    send_element(MODE_BAD, 32'hffff_ffff, 1'b1);
    send_element(MODE_BAD, 32'h0000_0000, 1'b0);
    write_scale_after_drain: begin
      drain();
      write_scale(32'h0000_0000);
    end
    send_element(MODE_FP32, 32'h7f80_0000, 1'b0);
    send_element(MODE_BF16, 32'h0000_ff80, 1'b1);
    send_element(MODE_FP16, 32'h0000_fc00, 1'b0);
    idle_on = 1'b0;
    send_random(40);
    idle_on = 1'b1;
    foreach (scales[k]) begin
      drain();
      write_scale(scales[k]);
      send_random(25);
    end
    drain();
    write_scale($urandom());
    send_random(40);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
